### src/ipp_pkg.sv
`timescale 1ns / 1ps

package ipp_pkg;

  // Packet framing
  localparam int unsigned PKT_LEN  = 11;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned DATA_LEN = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE   = 1'b1;
  localparam logic [7:0] HEADER_RST = 8'h55;
  localparam logic [7:0] TYPE_RST   = 8'h53;

  // Decoupling queue between parser and unwrap stage
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Angle words of one good packet, little-endian from bytes 2 to 7
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } angle_pkt_t;

endpackage

### src/ipp_front.sv
`timescale 1ns / 1ps

module ipp_front import ipp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  rx_valid_i,
  output logic                  rx_ready_o,
  input  logic                  queue_full_i,
  output logic                  push_o,
  output angle_pkt_t            pkt_o
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PKT_LEN - 1);
  localparam logic [POS_W-1:0] FIRST_DAT = POS_W'(2);
  localparam logic [POS_W-1:0] END_DAT   = POS_W'(2 + DATA_LEN);

  logic [7:0]       header_q, type_q;
  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       data_q [DATA_LEN];
  logic             accept;
  logic             data_we;
  logic [2:0]       data_idx;

  // The parser stalls whenever the queue is full, since any byte may finish a packet.
  assign rx_ready_o = !queue_full_i;
  assign accept     = rx_valid_i && rx_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RST;
      type_q   <= TYPE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_HEADER) header_q <= cfg_data_i;
      if (cfg_index_i == REG_TYPE)   type_q   <= cfg_data_i;
    end
  end

  // Framing decisions for one byte.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    push_o  = 1'b0;
    data_we = 1'b0;
    case (phase_q)
      PH_TYPE: begin
        if (rx_byte_i == type_q) begin
          sum_d   = sum_q + rx_byte_i;
          pos_d   = FIRST_DAT;
          phase_d = PH_DATA;
        end else if (rx_byte_i == header_q) begin
          sum_d   = rx_byte_i;
          pos_d   = POS_W'(1);
          phase_d = PH_TYPE;
        end else begin
          pos_d   = '0;
          phase_d = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (pos_q >= FIRST_DAT && pos_q <= LAST_POS) begin
          data_we = pos_q < END_DAT;
          if (pos_q != LAST_POS) begin
            sum_d = sum_q + rx_byte_i;
            pos_d = pos_q + POS_W'(1);
          end else begin
            pos_d   = '0;
            phase_d = PH_HUNT;
            push_o  = accept && (sum_q == rx_byte_i);
          end
        end else begin
          pos_d   = '0;
          phase_d = PH_HUNT;
          if (rx_byte_i == header_q) begin
            sum_d   = rx_byte_i;
            pos_d   = POS_W'(1);
            phase_d = PH_TYPE;
          end
        end
      end
      default: begin
        pos_d   = '0;
        phase_d = PH_HUNT;
        if (rx_byte_i == header_q) begin
          sum_d   = rx_byte_i;
          pos_d   = POS_W'(1);
          phase_d = PH_TYPE;
        end
      end
    endcase
  end

  // Parser state advances on every byte transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      sum_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
    end
  end

  // Angle bytes are kept at fixed slots; the checksum byte is never stored.
  assign data_idx = 3'(pos_q - FIRST_DAT);

  always_ff @(posedge clk_i) begin
    if (accept && data_we) begin
      data_q[data_idx] <= rx_byte_i;
    end
  end

  assign pkt_o.roll  = {data_q[1], data_q[0]};
  assign pkt_o.pitch = {data_q[3], data_q[2]};
  assign pkt_o.yaw   = {data_q[5], data_q[4]};

endmodule

### src/ipp_queue.sv
`timescale 1ns / 1ps

module ipp_queue import ipp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  angle_pkt_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output angle_pkt_t pop_data_o,
  output logic       empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  angle_pkt_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o     = cnt_q == CNT_W'(DEPTH);
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule

### src/ipp_back.sv
`timescale 1ns / 1ps

module ipp_back import ipp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  angle_pkt_t         pkt_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_o,
  output logic signed [15:0] pitch_o,
  output logic signed [15:0] yaw_o,
  output logic signed [15:0] turns_o,
  output logic signed [32:0] total_yaw_o
);

  localparam logic signed [17:0] JUMP_HI = 18'sd32768;
  localparam logic signed [17:0] JUMP_LO = -18'sd32768;
  localparam logic signed [15:0] TURN_MIN = 16'sh8000;
  localparam logic signed [15:0] TURN_MAX = 16'sh7fff;

  logic signed [15:0] prev_yaw_q;
  logic signed [15:0] turns_q, turns_d;
  logic signed [17:0] diff;
  logic signed [32:0] total_d;
  logic               out_valid_q;

  // Take a packet whenever the output register is free or being emptied.
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  // Yaw unwrap against the previous good packet, with a saturating count.
  always_comb begin
    diff    = {{2{pkt_i.yaw[15]}}, pkt_i.yaw} - {{2{prev_yaw_q[15]}}, prev_yaw_q};
    turns_d = turns_q;
    if (diff > JUMP_HI) begin
      if (turns_q != TURN_MIN) turns_d = turns_q - 16'sd1;
    end else if (diff < JUMP_LO) begin
      if (turns_q != TURN_MAX) turns_d = turns_q + 16'sd1;
    end
    total_d = {turns_d[15], turns_d, 16'h0000} + {{17{pkt_i.yaw[15]}}, pkt_i.yaw};
  end

  // Unwrap state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_yaw_q  <= '0;
      turns_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        prev_yaw_q  <= pkt_i.yaw;
        turns_q     <= turns_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      roll_o      <= pkt_i.roll;
      pitch_o     <= pkt_i.pitch;
      yaw_o       <= pkt_i.yaw;
      turns_o     <= turns_d;
      total_yaw_o <= total_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/imu_angle_packet_parser.sv
`timescale 1ns / 1ps

// Angle packet deframer for a serial IMU byte stream, with yaw unwrapping.
// Input channel: one received byte per transfer on rx_byte_i (rx_valid_i /
// rx_ready_o). The parser hunts for the header byte, checks the type byte,
// gathers the 11-byte packet and compares the 8-bit sum of bytes 0..9 with
// byte 10. Packets with a bad checksum produce nothing.
// Output channel: one transfer per good packet carrying roll, pitch and yaw
// in raw units of 180/32768 degree, the saturating turn count and the
// continuous yaw turns*65536+yaw (out_valid_o / out_ready_i).
// Configuration: cfg_we_i writes register cfg_index_i (0 header byte,
// 1 packet type byte); write only while the block is idle.
// Throughput is one byte per cycle while rx_ready_o is high. After the
// transfer of a packet's checksum byte, the packet enters the queue, and
// the unwrap stage then loads the output register from it once that
// register is free.
// When the receiver stalls, good packets collect in the queue (QUEUE_DEPTH
// entries); only once it is full does rx_ready_o drop.
// Reset clears the parser to the hunt phase, empties the queue, zeroes the
// turn count and previous yaw, and restores both configuration registers.

module imu_angle_packet_parser import ipp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  rx_valid_i,
  output logic                  rx_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    roll_o,
  output logic signed [15:0]    pitch_o,
  output logic signed [15:0]    yaw_o,
  output logic signed [15:0]    turns_o,
  output logic signed [32:0]    total_yaw_o
);

  logic       push, pop, full, empty;
  angle_pkt_t push_pkt, pop_pkt;

  // Byte parser and checksum.
  ipp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (rx_byte_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .queue_full_i (full),
    .push_o       (push),
    .pkt_o        (push_pkt)
  );

  // Queue of good packets.
  ipp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_pkt),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_pkt),
    .empty_o     (empty)
  );

  // Yaw unwrap and output register.
  ipp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pkt_i       (pop_pkt),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .roll_o      (roll_o),
    .pitch_o     (pitch_o),
    .yaw_o       (yaw_o),
    .turns_o     (turns_o),
    .total_yaw_o (total_yaw_o)
  );

  // A finished packet never arrives at a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("packet pushed into a full queue");

  // The queue cannot be full and empty at once.
  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && empty))
    else $error("queue reports full and empty together");

  // The continuous yaw always agrees with the turn count and yaw shown.
  a_total_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_yaw_o ==
      ({turns_o[15], turns_o, 16'h0000} + {{17{yaw_o[15]}}, yaw_o}))
    else $error("total yaw inconsistent with turns and yaw");

  // Nothing is popped from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("pop from an empty queue");

endmodule
